### rtl/qwi_pkg.sv
// ----------------------------------------------------------------------------
// qwi_pkg
// shared constants, codes and pipeline payload type for the waypoint
// interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package qwi_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int TIME_W      = 16;
    localparam int TAU_W       = 17;
    localparam int DIV_STEPS   = 16;

    localparam logic [TAU_W-1:0] TAU_ONE = TAU_W'(65536);

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // segment data that rides along the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]              seg;
        logic                          clamp;
        logic signed [VALUE_WIDTH-1:0] p0_y;
        logic signed [VALUE_WIDTH-1:0] pf_y;
        logic signed [VALUE_WIDTH-1:0] p0_z;
        logic signed [VALUE_WIDTH-1:0] pf_z;
        logic signed [VALUE_WIDTH-1:0] p0_rot;
        logic signed [VALUE_WIDTH-1:0] pf_rot;
    } t_pay;

endpackage

`default_nettype wire

### rtl/qwi_if.sv
// ----------------------------------------------------------------------------
// qwi_in_if / qwi_out_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface qwi_in_if import qwi_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [IDX_W-1:0]              point_index;
    logic [TIME_W-1:0]             item_time;
    logic signed [VALUE_WIDTH-1:0] value_y;
    logic signed [VALUE_WIDTH-1:0] value_z;
    logic signed [VALUE_WIDTH-1:0] value_rot;

    modport source (output valid, req_type, point_index, item_time, value_y, value_z,
                    value_rot, input ready);
    modport sink   (input valid, req_type, point_index, item_time, value_y, value_z,
                    value_rot, output ready);
endinterface

interface qwi_out_if import qwi_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_y;
    logic signed [VALUE_WIDTH-1:0] out_z;
    logic signed [VALUE_WIDTH-1:0] out_rot;
    logic [IDX_W-1:0]              segment_used;
    logic                          time_clamped;

    modport source (output valid, out_y, out_z, out_rot, segment_used, time_clamped,
                    input ready);
    modport sink   (input valid, out_y, out_z, out_rot, segment_used, time_clamped,
                    output ready);
endinterface

`default_nettype wire

### rtl/quintic_waypoint_interpolator_top.sv
// ----------------------------------------------------------------------------
// quintic_waypoint_interpolator_top
// waypoint table with segment search, pipelined tau divider and quintic blend
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  i_req     in   valid/ready      req_type, point_index, item_time, values
//  o_res     out  valid/ready      out_y, out_z, out_rot, segment_used, clamp
//  i_cfg     in   write enable     point_count
//
//  one item enters per cycle while the output does not stall; a query passes
//  the table read, the 16-stage restoring divider and the multiply stages.
//  a write item updates the table at its transfer and yields no result.
//  reset clears valid bits and point_count (to 2); the table is undefined.
//  the whole pipeline holds while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_waypoint_interpolator_top import qwi_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [CNT_W-1:0] i_cfg_data,
    qwi_in_if.sink          i_req,
    qwi_out_if.source       o_res
);

    localparam int NST = 9 + DIV_STEPS;
    localparam int ENT_W = TIME_W + 3 * VALUE_WIDTH;

    // global advance
    logic en;
    assign en = !o_res.valid || o_res.ready;
    assign i_req.ready = en;

    logic in_xfer;
    assign in_xfer = i_req.valid && en;

    // config register
    logic [CNT_W-1:0] r_point_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CNT_W'(2);
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // waypoint table: times in flops for the search, full entries in memory
    logic [TIME_W-1:0] r_wt [MAX_POINTS];
    logic [ENT_W-1:0]  mem  [MAX_POINTS];
    logic              wr_en;
    assign wr_en = in_xfer && (i_req.req_type == REQ_WRITE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wt[i_req.point_index] <= i_req.item_time;
            mem[i_req.point_index]  <= {i_req.item_time, i_req.value_y, i_req.value_z,
                                        i_req.value_rot};
        end
    end

    // segment search on the incoming time
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] n_seg;
    logic             n_below;
    logic             n_above;

    always_comb begin
        if (r_point_count < CNT_W'(2)) begin
            n_cnt = CNT_W'(2);
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            n_cnt = CNT_W'(MAX_POINTS);
        end else begin
            n_cnt = r_point_count;
        end
        n_last  = IDX_W'(n_cnt - CNT_W'(1));
        n_below = i_req.item_time < r_wt[0];
        n_above = i_req.item_time > r_wt[n_last];
        n_seg   = IDX_W'(n_cnt - CNT_W'(2));
        for (int i = MAX_POINTS - 2; i >= 0; i--) begin
            if ((CNT_W'(i + 1) < n_cnt) && (i_req.item_time < r_wt[i + 1])) begin
                n_seg = IDX_W'(i);
            end
        end
        if (n_below) begin
            n_seg = '0;
        end else if (n_above) begin
            n_seg = IDX_W'(n_cnt - CNT_W'(2));
        end
    end

    // valid bits
    logic [NST-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], in_xfer && (i_req.req_type == REQ_QUERY)};
        end
    end

    // stage a: registered table read
    logic [ENT_W-1:0]  r_a_e0, r_a_e1;
    logic [TIME_W-1:0] r_a_t;
    logic [IDX_W-1:0]  r_a_seg;
    logic              r_a_below, r_a_above;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_e0    <= mem[n_seg];
            r_a_e1    <= mem[n_seg + IDX_W'(1)];
            r_a_t     <= i_req.item_time;
            r_a_seg   <= n_seg;
            r_a_below <= n_below;
            r_a_above <= n_above;
        end
    end

    // stage b: numerator, denominator and end cases
    logic [TIME_W-1:0] a_t0, a_tf;
    logic              a_zero, a_one;
    t_pay              a_pay;
    assign a_t0 = r_a_e0[ENT_W-1 -: TIME_W];
    assign a_tf = r_a_e1[ENT_W-1 -: TIME_W];
    assign a_zero = r_a_below || (!r_a_above && (r_a_t <= a_t0));
    assign a_one = !a_zero && (r_a_above || (r_a_t >= a_tf) || (a_tf <= a_t0));
    assign a_pay = '{seg: r_a_seg, clamp: r_a_below || r_a_above,
                     p0_y: r_a_e0[3*VALUE_WIDTH-1 -: VALUE_WIDTH],
                     pf_y: r_a_e1[3*VALUE_WIDTH-1 -: VALUE_WIDTH],
                     p0_z: r_a_e0[2*VALUE_WIDTH-1 -: VALUE_WIDTH],
                     pf_z: r_a_e1[2*VALUE_WIDTH-1 -: VALUE_WIDTH],
                     p0_rot: r_a_e0[VALUE_WIDTH-1:0],
                     pf_rot: r_a_e1[VALUE_WIDTH-1:0]};

    t_pay              r_b_pay;
    logic [TIME_W-1:0] r_b_num, r_b_den;
    logic              r_b_zero, r_b_one;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pay  <= a_pay;
            r_b_num  <= r_a_t - a_t0;
            r_b_den  <= a_tf - a_t0;
            r_b_zero <= a_zero;
            r_b_one  <= a_one;
        end
    end

    // divider: one quotient bit per stage
    t_pay              r_d_pay  [DIV_STEPS];
    logic [TIME_W-1:0] r_d_rem  [DIV_STEPS];
    logic [TIME_W-1:0] r_d_den  [DIV_STEPS];
    logic [TIME_W-1:0] r_d_q    [DIV_STEPS];
    logic              r_d_zero [DIV_STEPS];
    logic              r_d_one  [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        logic [TIME_W-1:0] rem_in, den_in, q_in;
        logic [TIME_W:0]   sh;
        if (en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                if (k == 0) begin
                    rem_in = r_b_num;
                    den_in = r_b_den;
                    q_in   = '0;
                    r_d_pay[k]  <= r_b_pay;
                    r_d_zero[k] <= r_b_zero;
                    r_d_one[k]  <= r_b_one;
                end else begin
                    rem_in = r_d_rem[k-1];
                    den_in = r_d_den[k-1];
                    q_in   = r_d_q[k-1];
                    r_d_pay[k]  <= r_d_pay[k-1];
                    r_d_zero[k] <= r_d_zero[k-1];
                    r_d_one[k]  <= r_d_one[k-1];
                end
                sh = {rem_in, 1'b0};
                if (sh >= {1'b0, den_in}) begin
                    r_d_rem[k] <= TIME_W'(sh - {1'b0, den_in});
                    r_d_q[k]   <= {q_in[TIME_W-2:0], 1'b1};
                end else begin
                    r_d_rem[k] <= TIME_W'(sh);
                    r_d_q[k]   <= {q_in[TIME_W-2:0], 1'b0};
                end
                r_d_den[k] <= den_in;
            end
        end
    end

    // stage c: tau with end cases
    t_pay             r_c_pay;
    logic [TAU_W-1:0] r_c_tau;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pay <= r_d_pay[DIV_STEPS-1];
            if (r_d_zero[DIV_STEPS-1]) begin
                r_c_tau <= '0;
            end else if (r_d_one[DIV_STEPS-1]) begin
                r_c_tau <= TAU_ONE;
            end else begin
                r_c_tau <= {1'b0, r_d_q[DIV_STEPS-1]};
            end
        end
    end

    // stage d: tau squared
    t_pay             r_e_pay;
    logic [TAU_W-1:0] r_e_tau, r_e_t2;
    logic [2*TAU_W-1:0] c_sq;
    assign c_sq = (2*TAU_W)'(r_c_tau) * (2*TAU_W)'(r_c_tau) + (2*TAU_W)'(32768);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_pay <= r_c_pay;
            r_e_tau <= r_c_tau;
            r_e_t2  <= c_sq[TAU_W+15:16];
        end
    end

    // stage e: tau cubed and inner polynomial
    t_pay               r_f_pay;
    logic [TAU_W-1:0]   r_f_t3;
    logic [19:0]        r_f_inner;
    logic [2*TAU_W-1:0] e_cu;
    logic [21:0]        e_inner;
    assign e_cu = (2*TAU_W)'(r_e_t2) * (2*TAU_W)'(r_e_tau) + (2*TAU_W)'(32768);
    assign e_inner = 22'(655360) + 22'(6) * 22'(r_e_t2) - 22'(15) * 22'(r_e_tau);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_pay   <= r_e_pay;
            r_f_t3    <= e_cu[TAU_W+15:16];
            r_f_inner <= e_inner[19:0];
        end
    end

    // stage f: blend product
    t_pay        r_g_pay;
    logic [37:0] r_g_prod;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_pay  <= r_f_pay;
            r_g_prod <= 38'(r_f_t3) * 38'(r_f_inner) + 38'(32768);
        end
    end

    // stage g: round and limit blend
    t_pay             r_h_pay;
    logic [TAU_W-1:0] r_h_s;
    logic [21:0]      g_s;
    assign g_s = r_g_prod[37:16];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_pay <= r_g_pay;
            r_h_s   <= (g_s > 22'(TAU_ONE)) ? TAU_ONE : g_s[TAU_W-1:0];
        end
    end

    // stage h: span times blend, one multiplier per axis
    localparam int PW = VALUE_WIDTH + TAU_W + 2;
    t_pay                 r_i_pay;
    logic signed [PW-1:0] r_i_py, r_i_pz, r_i_pr;

    function automatic logic signed [PW-1:0] span_mul(
        input logic signed [VALUE_WIDTH-1:0] p0,
        input logic signed [VALUE_WIDTH-1:0] pf,
        input logic [TAU_W-1:0]              s
    );
        logic signed [VALUE_WIDTH:0] d;
        d = VALUE_WIDTH'(1) == 0 ? '0 : ((VALUE_WIDTH+1)'(pf) - (VALUE_WIDTH+1)'(p0));
        return PW'(d) * PW'($signed({1'b0, s}));
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_pay <= r_h_pay;
            r_i_py  <= span_mul(r_h_pay.p0_y, r_h_pay.pf_y, r_h_s);
            r_i_pz  <= span_mul(r_h_pay.p0_z, r_h_pay.pf_z, r_h_s);
            r_i_pr  <= span_mul(r_h_pay.p0_rot, r_h_pay.pf_rot, r_h_s);
        end
    end

    // stage i: round, add start value, saturate into output register
    function automatic logic signed [VALUE_WIDTH-1:0] finish(
        input logic signed [VALUE_WIDTH-1:0] p0,
        input logic signed [PW-1:0]          prod
    );
        logic signed [PW-1:0] rnd;
        logic signed [PW-1:0] sum;
        rnd = (prod + PW'(32768)) >>> 16;
        sum = rnd + PW'(p0);
        if (sum > PW'((1 << (VALUE_WIDTH - 1)) - 1)) begin
            return VALUE_WIDTH'((1 << (VALUE_WIDTH - 1)) - 1);
        end else if (sum < -PW'(1 << (VALUE_WIDTH - 1))) begin
            return VALUE_WIDTH'(-(1 << (VALUE_WIDTH - 1)));
        end
        return VALUE_WIDTH'(sum);
    endfunction

    logic signed [VALUE_WIDTH-1:0] r_o_y, r_o_z, r_o_rot;
    logic [IDX_W-1:0]              r_o_seg;
    logic                          r_o_clamp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_y     <= finish(r_i_pay.p0_y, r_i_py);
            r_o_z     <= finish(r_i_pay.p0_z, r_i_pz);
            r_o_rot   <= finish(r_i_pay.p0_rot, r_i_pr);
            r_o_seg   <= r_i_pay.seg;
            r_o_clamp <= r_i_pay.clamp;
        end
    end

    assign o_res.valid        = r_vld[NST-1];
    assign o_res.out_y        = r_o_y;
    assign o_res.out_z        = r_o_z;
    assign o_res.out_rot      = r_o_rot;
    assign o_res.segment_used = r_o_seg;
    assign o_res.time_clamped = r_o_clamp;

    // checks
    a_tau_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS+2] |-> (r_c_tau <= TAU_ONE))
        else $error("tau above one");

    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STEPS+6] |-> (r_h_s <= TAU_ONE))
        else $error("blend above one");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_a_seg <= IDX_W'(MAX_POINTS - 2)))
        else $error("segment past last");

    a_table_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_wt[$past(i_req.point_index)] == $past(i_req.item_time)))
        else $error("waypoint time not stored");

endmodule

`default_nettype wire

### verif/quintic_waypoint_interpolator_top_test.sv
// ----------------------------------------------------------------------------
// quintic_waypoint_interpolator_top_test
// self-checking bench: waypoint writes and time queries are driven through
// the request channel, each query is predicted in-bench and compared field
// by field with the result channel, across several point_count settings
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_waypoint_interpolator_top_test;
    import qwi_pkg::*;

    typedef struct {
        logic                          req_type;
        logic [IDX_W-1:0]              point_index;
        logic [TIME_W-1:0]             item_time;
        logic signed [VALUE_WIDTH-1:0] value_y;
        logic signed [VALUE_WIDTH-1:0] value_z;
        logic signed [VALUE_WIDTH-1:0] value_rot;
    } t_req_item;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] out_y;
        logic signed [VALUE_WIDTH-1:0] out_z;
        logic signed [VALUE_WIDTH-1:0] out_rot;
        logic [IDX_W-1:0]              segment_used;
        logic                          time_clamped;
    } t_pose;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    qwi_in_if  req_if ();
    qwi_out_if res_if ();

    quintic_waypoint_interpolator_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // bench copy of the waypoint table and point count
    logic [TIME_W-1:0]             tbl_time [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] tbl_y    [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] tbl_z    [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] tbl_rot  [MAX_POINTS];
    logic [CNT_W-1:0]              live_count;

    t_req_item pending_reqs [$];
    t_pose     expected_poses [$];

    int  errors;
    int  queries_seen;
    int  writes_seen;
    int  clamped_seen;
    int  idle_cycles;
    bit  in_fire;
    bit  hold_req;
    int  hold_left;
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  stall_timer;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // quintic smoothstep blend of tau (0..65536)
    function automatic longint quintic_blend(longint tau);
        longint t2, t3, inner, s;
        t2    = (tau * tau + 32768) >> 16;
        t3    = (t2 * tau + 32768) >> 16;
        inner = 655360 + 6 * t2 - 15 * tau;
        s     = (t3 * inner + 32768) >> 16;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] blend_axis(longint p0, longint pf,
                                                                 longint s);
        longint r;
        r = p0 + (((pf - p0) * s + 32768) >>> 16);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return VALUE_WIDTH'(r);
    endfunction

    // expected pose for a query at time t
    function automatic t_pose predict_pose(logic [TIME_W-1:0] t);
        t_pose  p;
        int     n, seg;
        bit     clamp;
        longint t0, tf, tau, s;
        n = live_count;
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        clamp = 1'b0;
        if (t < tbl_time[0]) begin
            seg = 0;
            clamp = 1'b1;
        end else if (t > tbl_time[n-1]) begin
            seg = n - 2;
            clamp = 1'b1;
        end else begin
            seg = n - 2;
            for (int i = 0; i + 1 < n; i++) begin
                if (t < tbl_time[i+1]) begin
                    seg = i;
                    break;
                end
            end
        end
        t0 = tbl_time[seg];
        tf = tbl_time[seg+1];
        if (clamp && t < tbl_time[0]) tau = 0;
        else if (clamp) tau = 65536;
        else if (t <= t0) tau = 0;
        else if (t >= tf || tf <= t0) tau = 65536;
        else tau = ((longint'(t) - t0) << 16) / (tf - t0);
        s = quintic_blend(tau);
        p.out_y        = blend_axis(tbl_y[seg], tbl_y[seg+1], s);
        p.out_z        = blend_axis(tbl_z[seg], tbl_z[seg+1], s);
        p.out_rot      = blend_axis(tbl_rot[seg], tbl_rot[seg+1], s);
        p.segment_used = IDX_W'(seg);
        p.time_clamped = clamp;
        return p;
    endfunction

    // request side: accept, update table or queue expectation
    always @(posedge i_clk) begin
        in_fire = i_rst_n && req_if.valid && req_if.ready;
        if (in_fire) begin
            if (req_if.req_type == REQ_WRITE) begin
                tbl_time[req_if.point_index] = req_if.item_time;
                tbl_y[req_if.point_index]    = req_if.value_y;
                tbl_z[req_if.point_index]    = req_if.value_z;
                tbl_rot[req_if.point_index]  = req_if.value_rot;
                writes_seen++;
            end else begin
                expected_poses.insert(expected_poses.size(),
                                      predict_pose(req_if.item_time));
                queries_seen++;
            end
        end
    end

    // result side: compare against oldest expectation
    always @(posedge i_clk) begin
        t_pose exp_p;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t unexpected result y=%0d z=%0d rot=%0d", $time,
                         res_if.out_y, res_if.out_z, res_if.out_rot);
                errors++;
            end else begin
                exp_p = expected_poses.pop_front();
                if (exp_p.time_clamped) clamped_seen++;
                if (res_if.out_y !== exp_p.out_y) begin
                    $display("%0t out_y exp %0d got %0d", $time, exp_p.out_y, res_if.out_y);
                    errors++;
                end
                if (res_if.out_z !== exp_p.out_z) begin
                    $display("%0t out_z exp %0d got %0d", $time, exp_p.out_z, res_if.out_z);
                    errors++;
                end
                if (res_if.out_rot !== exp_p.out_rot) begin
                    $display("%0t out_rot exp %0d got %0d", $time, exp_p.out_rot,
                             res_if.out_rot);
                    errors++;
                end
                if (res_if.segment_used !== exp_p.segment_used) begin
                    $display("%0t segment_used exp %0d got %0d", $time,
                             exp_p.segment_used, res_if.segment_used);
                    errors++;
                end
                if (res_if.time_clamped !== exp_p.time_clamped) begin
                    $display("%0t time_clamped exp %0d got %0d", $time,
                             exp_p.time_clamped, res_if.time_clamped);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        t_req_item it;
        if (i_rst_n && (!req_if.valid || in_fire)) begin
            if (gap_left > 0) begin
                req_if.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                it = pending_reqs.pop_front();
                req_if.valid       <= 1'b1;
                req_if.req_type    <= it.req_type;
                req_if.point_index <= it.point_index;
                req_if.item_time   <= it.item_time;
                req_if.value_y     <= it.value_y;
                req_if.value_z     <= it.value_z;
                req_if.value_rot   <= it.value_rot;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 120);
        end else begin
            stall_timer = stall_timer - 1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 1) == 1);
                2: res_if.ready <= ($urandom_range(0, 7) != 0);
                default: res_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic add_write(int idx, int t, int y, int z, int rot);
        t_req_item it;
        it.req_type    = REQ_WRITE;
        it.point_index = IDX_W'(idx);
        it.item_time   = TIME_W'(t);
        it.value_y     = VALUE_WIDTH'(y);
        it.value_z     = VALUE_WIDTH'(z);
        it.value_rot   = VALUE_WIDTH'(rot);
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic add_query(int t);
        t_req_item it;
        it.req_type    = REQ_QUERY;
        it.point_index = IDX_W'($urandom);
        it.item_time   = TIME_W'(t);
        it.value_y     = VALUE_WIDTH'($urandom);
        it.value_z     = VALUE_WIDTH'($urandom);
        it.value_rot   = VALUE_WIDTH'($urandom);
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    // drain everything, then let the pipeline settle
    task automatic wait_quiet();
        wait (pending_reqs.size() == 0 && !req_if.valid && expected_poses.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_point_count(logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        live_count = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // fresh table with sorted random times
    task automatic load_sorted_table();
        int times [$];
        for (int i = 0; i < MAX_POINTS; i++)
            times.insert(times.size(), $urandom_range(0, 65535));
        times.sort();
        for (int i = 0; i < MAX_POINTS; i++)
            add_write(i, times[i], $urandom, $urandom, $urandom);
    endtask

    // stimulus
    initial begin
        logic [CNT_W-1:0] counts [10] = '{3, 8, 2, 5, 0, 15, 1, 7, 4, 6};
        int n, lo, hi;
        errors = 0; queries_seen = 0; writes_seen = 0; clamped_seen = 0;
        idle_cycles = 0; in_fire = 0; hold_req = 0; hold_left = 0;
        burst_left = 0; gap_left = 0; stall_mode = 0; stall_timer = 0;
        live_count = 2;
        for (int i = 0; i < MAX_POINTS; i++) begin
            tbl_time[i] = '0; tbl_y[i] = '0; tbl_z[i] = '0; tbl_rot[i] = '0;
        end
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_WRITE;
        req_if.point_index = '0;
        req_if.item_time = '0;
        req_if.value_y = '0;
        req_if.value_z = '0;
        req_if.value_rot = '0;
        res_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme values, equal times, clamping at both ends
        add_write(0, 10, -32768, 32767, 0);
        add_write(1, 1000, 32767, -32768, 4096);
        add_write(2, 1000, 100, 200, -300);
        add_write(3, 3000, -32768, 32767, 32767);
        add_write(4, 3001, 32767, -32768, -32768);
        add_write(5, 40000, 0, 0, 0);
        add_write(6, 50000, 12345, -12345, 1);
        add_write(7, 65535, -1, 1, -1);
        add_query(0);
        add_query(10);
        add_query(505);
        add_query(999);
        add_query(1000);
        add_query(1001);
        add_query(65535);
        wait_quiet();
        write_point_count(8);
        add_query(1000);
        add_query(2000);
        add_query(3000);
        add_query(3001);
        add_query(45000);
        add_query(65535);
        add_query(9);
        wait_quiet();

        // random phases over several point counts
        foreach (counts[c]) begin
            write_point_count(counts[c]);
            n = (counts[c] < 2) ? 2 : (counts[c] > MAX_POINTS ? MAX_POINTS : counts[c]);
            if (c == 3) hold_req = 1'b1;
            load_sorted_table();
            for (int k = 0; k < 95; k++) begin
                if ($urandom_range(0, 9) < 2) begin
                    add_write($urandom_range(0, MAX_POINTS - 1), $urandom,
                              $urandom, $urandom, $urandom);
                end else if ($urandom_range(0, 9) < 2) begin
                    add_query($urandom_range(0, 65535));
                end else begin
                    lo = tbl_time[0];
                    hi = tbl_time[n-1];
                    if (hi < lo) hi = lo;
                    lo = (lo > 20) ? lo - 20 : 0;
                    hi = (hi < 65515) ? hi + 20 : 65535;
                    add_query($urandom_range(lo, hi));
                end
            end
            wait_quiet();
        end

        $display("run covered %0d queries (%0d clamped) and %0d waypoint writes",
                 queries_seen, clamped_seen, writes_seen);
        $display("point_count settings swept from out-of-range low through the maximum");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/qwi_pkg.sv
rtl/qwi_if.sv
rtl/quintic_waypoint_interpolator_top.sv
verif/quintic_waypoint_interpolator_top_test.sv
